>>> rtl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the go-to-goal proportional controller:
// datapath widths, cell payload, arctangent table, register map.
// ----------------------------------------------------------------------------
package gtg_pkg;

   // default parameter values
   localparam int FRAC_BITS_DEF     = 10;
   localparam int CORDIC_STAGES_DEF = 14;

   // field widths
   localparam int POS_W   = 16;  // pose / target coordinates
   localparam int HD_W    = 13;  // heading
   localparam int GAIN_W  = 14;
   localparam int SPD_W   = 15;  // speed limit, linear speed, distance tolerance
   localparam int HTOL_W  = 13;
   localparam int TURN_W  = 14;

   // offset and distance datapath
   localparam int DXY_W   = POS_W + 1;     // target minus pose
   localparam int SQ_W    = 32;            // one square, always below 2^32
   localparam int RAD_W   = 34;            // sum of squares, padded to even width
   localparam int ROOT_W  = RAD_W / 2;     // one root bit per cell
   localparam int REM_W   = ROOT_W + 2;

   // CORDIC datapath
   localparam int GUARD_W    = 8;
   localparam int XY_W       = 28;
   localparam int Z_W        = 34;
   localparam int ATAN_DEPTH = 20;
   localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;

   // angle conversion and decision
   localparam int MAG_W  = 32;
   localparam int PROD_W = 64;
   localparam logic [MAG_W-1:0] TWO_PI_Q29 = 32'd3373259426;
   localparam int BMAG_W = 17;
   localparam int ERR_W  = 19;
   localparam int SPROD_W = GAIN_W + ROOT_W;
   localparam logic signed [ERR_W-1:0] TURN_MAX = 19'sd8191;

   // register map (word index)
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_TARGET_X    = 3'd0;
   localparam logic [2:0] REG_TARGET_Y    = 3'd1;
   localparam logic [2:0] REG_SPEED_GAIN  = 3'd2;
   localparam logic [2:0] REG_SPEED_LIMIT = 3'd3;
   localparam logic [2:0] REG_DIST_TOL    = 3'd4;
   localparam logic [2:0] REG_HEAD_TOL    = 3'd5;

   // register reset values
   localparam logic [POS_W-1:0]  TARGET_X_RST    = 16'd1024;
   localparam logic [POS_W-1:0]  TARGET_Y_RST    = 16'd1024;
   localparam logic [GAIN_W-1:0] SPEED_GAIN_RST  = 14'd1024;
   localparam logic [SPD_W-1:0]  SPEED_LIMIT_RST = 15'd3072;
   localparam logic [SPD_W-1:0]  DIST_TOL_RST    = 15'd102;
   localparam logic [HTOL_W-1:0] HEAD_TOL_RST    = 13'd205;

   // payload handed from cell to cell
   typedef struct packed {
      logic                    vld;
      logic [HD_W-1:0]         hd;
      logic [XY_W-1:0]         cx;
      logic [XY_W-1:0]         cy;
      logic [Z_W-1:0]          cz;
      logic [RAD_W-1:0]        rad;
      logic [REM_W-1:0]        rem;
      logic [ROOT_W-1:0]       root;
   } gtg_cell_type;

   // atan(2^-i) in binary angle units, 2^32 per turn
   function automatic logic [31:0] atan_bam(input int idx);
      logic [31:0] v;
      unique case (idx)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/gtg_front.sv
// ----------------------------------------------------------------------------
// gtg_front
// Entry stages: offset to target, squares, quadrant pre-rotation, and the
// sum of squares that seeds the root. Emits the first cell payload.
// ----------------------------------------------------------------------------
module gtg_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_vld,
   input  logic [gtg_pkg::POS_W-1:0]      pose_x,
   input  logic [gtg_pkg::POS_W-1:0]      pose_y,
   input  logic [gtg_pkg::HD_W-1:0]       heading,
   input  logic [gtg_pkg::POS_W-1:0]      target_x,
   input  logic [gtg_pkg::POS_W-1:0]      target_y,
   output gtg_pkg::gtg_cell_type          cell_o
);
   import gtg_pkg::*;

   // stage 1: offset
   logic                    s1_vld_ff;
   logic signed [DXY_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [HD_W-1:0]         s1_hd_ff;

   // stage 2: squares and pre-rotation
   logic                    s2_vld_ff;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff;
   logic signed [2*DXY_W-1:0] sqx_full, sqy_full;
   logic [HD_W-1:0]         s2_hd_ff;
   logic [XY_W-1:0]         x_ff, y_ff, x_in, y_in;
   logic [Z_W-1:0]          z_ff, z_in;
   logic signed [XY_W-1:0]  gx, gy;

   // stage 3: sum of squares
   logic                    s3_vld_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [HD_W-1:0]         s3_hd_ff;
   logic [XY_W-1:0]         x3_ff, y3_ff;
   logic [Z_W-1:0]          z3_ff;

   assign dx_in = $signed({target_x[POS_W-1], target_x}) - $signed({pose_x[POS_W-1], pose_x});
   assign dy_in = $signed({target_y[POS_W-1], target_y}) - $signed({pose_y[POS_W-1], pose_y});

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      s1_hd_ff <= heading;
      if (reset) s1_vld_ff <= 1'b0;
      else       s1_vld_ff <= req_vld;
   end

   // offsets with guard bits
   assign gx = {{(XY_W-DXY_W-GUARD_W){dx_ff[DXY_W-1]}}, dx_ff, {GUARD_W{1'b0}}};
   assign gy = {{(XY_W-DXY_W-GUARD_W){dy_ff[DXY_W-1]}}, dy_ff, {GUARD_W{1'b0}}};

   assign sqx_full = dx_ff * dx_ff;
   assign sqy_full = dy_ff * dy_ff;

   // left half plane: rotate by a quarter turn toward the x axis
   always_comb begin
      x_in = gx;
      y_in = gy;
      z_in = '0;
      if (dx_ff[DXY_W-1]) begin
         if (!dy_ff[DXY_W-1]) begin
            x_in = gy;
            y_in = -gx;
            z_in = QUARTER_TURN;
         end else begin
            x_in = -gy;
            y_in = gx;
            z_in = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      sqx_ff   <= sqx_full[SQ_W-1:0];
      sqy_ff   <= sqy_full[SQ_W-1:0];
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      s2_hd_ff <= s1_hd_ff;
      if (reset) s2_vld_ff <= 1'b0;
      else       s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      rad_ff   <= RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
      x3_ff    <= x_ff;
      y3_ff    <= y_ff;
      z3_ff    <= z_ff;
      s3_hd_ff <= s2_hd_ff;
      if (reset) s3_vld_ff <= 1'b0;
      else       s3_vld_ff <= s2_vld_ff;
   end

   always_comb begin
      cell_o      = '0;
      cell_o.vld  = s3_vld_ff;
      cell_o.hd   = s3_hd_ff;
      cell_o.cx   = x3_ff;
      cell_o.cy   = y3_ff;
      cell_o.cz   = z3_ff;
      cell_o.rad  = rad_ff;
   end

endmodule

>>> rtl/gtg_cell.sv
// ----------------------------------------------------------------------------
// gtg_cell
// One cell of the chain: at most one CORDIC vectoring rotation and at most one root digit,
// registered and handed to the next cell.
// ----------------------------------------------------------------------------
module gtg_cell #(
   parameter int IDX           = 0,
   parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gtg_pkg::gtg_cell_type cell_i,
   output gtg_pkg::gtg_cell_type cell_o
);
   import gtg_pkg::*;

   localparam bit DO_ROT  = (IDX < CORDIC_STAGES) && (IDX < ATAN_DEPTH);
   localparam bit DO_ROOT = (IDX < ROOT_W);
   localparam logic [Z_W-1:0] ATAN_Z = {{(Z_W-32){1'b0}}, atan_bam(IDX)};

   gtg_cell_type cell_ff, cell_in;

   always_comb begin
      logic signed [XY_W-1:0] xs, ys;
      logic [REM_W+1:0]       rem_t, trial, diff;

      cell_in = cell_i;
      xs      = $signed(cell_i.cx) >>> IDX;
      ys      = $signed(cell_i.cy) >>> IDX;
      rem_t   = {cell_i.rem, cell_i.rad[RAD_W-1 -: 2]};
      trial   = {{(REM_W-ROOT_W){1'b0}}, cell_i.root, 2'b01};
      diff    = rem_t - trial;

      // rotate toward y = 0
      if (DO_ROT) begin
         if (!cell_i.cy[XY_W-1]) begin
            cell_in.cx = cell_i.cx + ys;
            cell_in.cy = cell_i.cy - xs;
            cell_in.cz = cell_i.cz + ATAN_Z;
         end else begin
            cell_in.cx = cell_i.cx - ys;
            cell_in.cy = cell_i.cy + xs;
            cell_in.cz = cell_i.cz - ATAN_Z;
         end
      end

      // restoring square root, one digit
      if (DO_ROOT) begin
         cell_in.rad = {cell_i.rad[RAD_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            cell_in.rem  = diff[REM_W-1:0];
            cell_in.root = {cell_i.root[ROOT_W-2:0], 1'b1};
         end else begin
            cell_in.rem  = rem_t[REM_W-1:0];
            cell_in.root = {cell_i.root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // cell register; reset empties the cell
   always_ff @(posedge clock) begin
      if (reset) cell_ff <= '0;
      else       cell_ff <= cell_in;
   end

   assign cell_o = cell_ff;

endmodule

>>> rtl/gtg_back.sv
// ----------------------------------------------------------------------------
// gtg_back
// Exit stages: angle to radians, heading error, speed product, and the
// turn / drive / arrived decision into the result register.
// ----------------------------------------------------------------------------
module gtg_back #(
   parameter int FRAC_BITS = gtg_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gtg_pkg::gtg_cell_type        cell_i,
   input  logic [gtg_pkg::GAIN_W-1:0]   speed_gain,
   input  logic [gtg_pkg::SPD_W-1:0]    speed_limit,
   input  logic [gtg_pkg::SPD_W-1:0]    distance_tolerance,
   input  logic [gtg_pkg::HTOL_W-1:0]   heading_tolerance,
   output logic                         rsp_valid,
   output logic [gtg_pkg::SPD_W-1:0]    rsp_linear_speed,
   output logic [gtg_pkg::TURN_W-1:0]   rsp_turn_rate
);
   import gtg_pkg::*;

   localparam int RND_SH = 61 - FRAC_BITS;
   localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (RND_SH - 1);

   // stage 1: angle magnitude
   logic              b1_vld_ff, b1_neg_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [Z_W-1:0]    zabs;
   logic [ROOT_W-1:0] b1_dist_ff;
   logic [HD_W-1:0]   b1_hd_ff;

   // stage 2: products
   logic              b2_vld_ff, b2_neg_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SPROD_W-1:0] sprod_ff, sprod_in;
   logic [ROOT_W-1:0] b2_dist_ff;
   logic [HD_W-1:0]   b2_hd_ff;

   // stage 3: bearing magnitude, saturated speed
   logic              b3_vld_ff, b3_neg_ff;
   logic [BMAG_W-1:0] bmag_ff;
   logic [PROD_W-1:0] rnd_sum, rnd_sh;
   logic [SPD_W-1:0]  lin3_ff, lin_in;
   logic [SPROD_W-1:0] lin_full;
   logic [ROOT_W-1:0] b3_dist_ff;
   logic [HD_W-1:0]   b3_hd_ff;

   // stage 4: heading error
   logic              b4_vld_ff;
   logic signed [ERR_W-1:0] err_ff, err_in, bearing;
   logic [SPD_W-1:0]  lin4_ff;
   logic [ROOT_W-1:0] b4_dist_ff;

   // stage 5: result register
   logic              vld_ff;
   logic [SPD_W-1:0]  lin_ff, lin_out;
   logic [TURN_W-1:0] turn_ff, turn_out;
   logic [ERR_W-1:0]  aerr;
   logic signed [ERR_W-1:0] turn_sat;

   assign zabs = cell_i.cz[Z_W-1] ? -cell_i.cz : cell_i.cz;

   always_ff @(posedge clock) begin
      mag_ff     <= zabs[MAG_W-1:0];
      b1_neg_ff  <= cell_i.cz[Z_W-1];
      b1_dist_ff <= cell_i.root;
      b1_hd_ff   <= cell_i.hd;
      if (reset) b1_vld_ff <= 1'b0;
      else       b1_vld_ff <= cell_i.vld;
   end

   assign prod_in  = mag_ff * TWO_PI_Q29;
   assign sprod_in = speed_gain * b1_dist_ff;

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      sprod_ff   <= sprod_in;
      b2_neg_ff  <= b1_neg_ff;
      b2_dist_ff <= b1_dist_ff;
      b2_hd_ff   <= b1_hd_ff;
      if (reset) b2_vld_ff <= 1'b0;
      else       b2_vld_ff <= b1_vld_ff;
   end

   // round half up to FRAC_BITS radians; floor the speed then clamp
   assign rnd_sum  = prod_ff + RND;
   assign rnd_sh   = rnd_sum >> RND_SH;
   assign lin_full = sprod_ff >> FRAC_BITS;
   assign lin_in   = (lin_full > SPROD_W'(speed_limit)) ? speed_limit : lin_full[SPD_W-1:0];

   always_ff @(posedge clock) begin
      bmag_ff    <= rnd_sh[BMAG_W-1:0];
      lin3_ff    <= lin_in;
      b3_neg_ff  <= b2_neg_ff;
      b3_dist_ff <= b2_dist_ff;
      b3_hd_ff   <= b2_hd_ff;
      if (reset) b3_vld_ff <= 1'b0;
      else       b3_vld_ff <= b2_vld_ff;
   end

   assign bearing = b3_neg_ff ? -$signed(ERR_W'(bmag_ff)) : $signed(ERR_W'(bmag_ff));
   assign err_in  = bearing - $signed({{(ERR_W-HD_W){b3_hd_ff[HD_W-1]}}, b3_hd_ff});

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      lin4_ff    <= lin3_ff;
      b4_dist_ff <= b3_dist_ff;
      if (reset) b4_vld_ff <= 1'b0;
      else       b4_vld_ff <= b3_vld_ff;
   end

   // decide: turn in place, drive, or arrived
   always_comb begin
      aerr = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
      if (err_ff > TURN_MAX)       turn_sat = TURN_MAX;
      else if (err_ff < -TURN_MAX) turn_sat = -TURN_MAX;
      else                         turn_sat = err_ff;
      lin_out  = '0;
      turn_out = '0;
      if (b4_dist_ff > ROOT_W'(distance_tolerance)) begin
         if (aerr > ERR_W'(heading_tolerance)) turn_out = turn_sat[TURN_W-1:0];
         else                                  lin_out  = lin4_ff;
      end
   end

   always_ff @(posedge clock) begin
      lin_ff  <= lin_out;
      turn_ff <= turn_out;
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= b4_vld_ff;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_linear_speed = lin_ff;
   assign rsp_turn_rate    = turn_ff;

endmodule

>>> rtl/go_to_goal_p_controller_top.sv
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_top
// Go-to-goal proportional controller: pose in, speed and turn commands out,
// through a chain of CORDIC / square-root cells.
// ----------------------------------------------------------------------------
//  channel   ports                                    handshake
//  request   req_pose_x, req_pose_y, req_heading      start, busy
//  result    rsp_linear_speed, rsp_turn_rate          rsp_valid (one cycle)
//  config    csr_psel ... csr_pready                  APB write, always ready
//
//  One request is taken every cycle; busy stays low.
//  A request passes the entry stages, NCELL cells and the exit stages, with
//  NCELL = max(min(CORDIC_STAGES, 20), 17). The 17 root digits and the
//  rotations set the chain length.
//  Reset clears every stage valid bit and restores the register defaults.
//  Results leave on rsp_valid and cannot be held off.
// ----------------------------------------------------------------------------
module go_to_goal_p_controller_top #(
   parameter int FRAC_BITS     = gtg_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [gtg_pkg::POS_W-1:0]     req_pose_x,
   input  logic [gtg_pkg::POS_W-1:0]     req_pose_y,
   input  logic [gtg_pkg::HD_W-1:0]      req_heading,
   // result
   output logic                          rsp_valid,
   output logic [gtg_pkg::SPD_W-1:0]     rsp_linear_speed,
   output logic [gtg_pkg::TURN_W-1:0]    rsp_turn_rate,
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gtg_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import gtg_pkg::*;

   localparam int ROT_N = (CORDIC_STAGES > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STAGES;
   localparam int NCELL = (ROT_N > ROOT_W) ? ROT_N : ROOT_W;
   localparam int LAT   = 3 + NCELL + 5;

   logic [POS_W-1:0]  target_x_ff, target_y_ff;
   logic [GAIN_W-1:0] speed_gain_ff;
   logic [SPD_W-1:0]  speed_limit_ff, dist_tol_ff;
   logic [HTOL_W-1:0] head_tol_ff;
   logic              csr_wr;
   logic [2:0]        csr_idx;
   logic              req_vld;

   gtg_cell_type chain [0:NCELL];

   assign busy       = 1'b0;
   assign req_vld    = start && !busy;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff    <= TARGET_X_RST;
         target_y_ff    <= TARGET_Y_RST;
         speed_gain_ff  <= SPEED_GAIN_RST;
         speed_limit_ff <= SPEED_LIMIT_RST;
         dist_tol_ff    <= DIST_TOL_RST;
         head_tol_ff    <= HEAD_TOL_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_TARGET_X:    target_x_ff    <= csr_pwdata[POS_W-1:0];
            REG_TARGET_Y:    target_y_ff    <= csr_pwdata[POS_W-1:0];
            REG_SPEED_GAIN:  speed_gain_ff  <= csr_pwdata[GAIN_W-1:0];
            REG_SPEED_LIMIT: speed_limit_ff <= csr_pwdata[SPD_W-1:0];
            REG_DIST_TOL:    dist_tol_ff    <= csr_pwdata[SPD_W-1:0];
            REG_HEAD_TOL:    head_tol_ff    <= csr_pwdata[HTOL_W-1:0];
            default: ;
         endcase
      end
   end

   // register reads, signed targets sign-extended
   always_comb begin
      unique case (csr_idx)
         REG_TARGET_X:    csr_prdata = {{(32-POS_W){target_x_ff[POS_W-1]}}, target_x_ff};
         REG_TARGET_Y:    csr_prdata = {{(32-POS_W){target_y_ff[POS_W-1]}}, target_y_ff};
         REG_SPEED_GAIN:  csr_prdata = 32'(speed_gain_ff);
         REG_SPEED_LIMIT: csr_prdata = 32'(speed_limit_ff);
         REG_DIST_TOL:    csr_prdata = 32'(dist_tol_ff);
         REG_HEAD_TOL:    csr_prdata = 32'(head_tol_ff);
         default:         csr_prdata = '0;
      endcase
   end

   gtg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_vld  (req_vld),
      .pose_x   (req_pose_x),
      .pose_y   (req_pose_y),
      .heading  (req_heading),
      .target_x (target_x_ff),
      .target_y (target_y_ff),
      .cell_o   (chain[0])
   );

   // cell chain
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      gtg_cell #(
         .IDX           (i),
         .CORDIC_STAGES (CORDIC_STAGES)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cell_i (chain[i]),
         .cell_o (chain[i+1])
      );
   end

   gtg_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cell_i             (chain[NCELL]),
      .speed_gain         (speed_gain_ff),
      .speed_limit        (speed_limit_ff),
      .distance_tolerance (dist_tol_ff),
      .heading_tolerance  (head_tol_ff),
      .rsp_valid          (rsp_valid),
      .rsp_linear_speed   (rsp_linear_speed),
      .rsp_turn_rate      (rsp_turn_rate)
   );

   // every request gives exactly one result
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("request without result");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without request");

   // never drive and turn at once
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_linear_speed == '0 || rsp_turn_rate == '0))
      else $error("speed and turn both commanded");

   // turn rate stays inside the symmetric range
   a_turn_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_turn_rate != {1'b1, {(TURN_W-1){1'b0}}}))
      else $error("turn rate out of range");

endmodule
